// ===== design/mmtn_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Multi-metric top-N tracker package
// Shared widths, command codes, state types and control bundles.
// ============================================================================
package mmtn_pkg;

    localparam int DATA_W           = 32;
    localparam int CMD_W            = 2;
    localparam int SEL_W            = 3;
    localparam int LIMIT_W          = 4;
    localparam int RATE_COUNT       = 8;
    localparam int MAX_RESULTS      = 10;
    localparam int DEF_HEAP_SLOTS   = 10;
    localparam int DEF_METRIC_COUNT = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_EXEC,
        T_WAIT_LANES,
        T_WAIT_READ
    } top_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_SIFT,
        L_LAST
    } lane_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_SCAN,
        R_FETCH,
        R_SHOW
    } rdr_state_t;

    typedef struct packed {
        logic clear;
        logic start;
    } lane_cmd_t;

    typedef struct packed {
        logic               start;
        logic [SEL_W-1:0]   sel;
        logic [LIMIT_W-1:0] limit;
    } rdr_cmd_t;

    function automatic int slot_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== design/multi_metric_top_n_tracker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Multi-metric top-N tracker
// Eight heap lanes keep the largest rates per metric; a read merger streams
// one lane's entries.
// Clear: the accepted item empties every heap, then the input reopens.
// Offer: a lane whose rate beats its root sifts the new entry down one heap
// level at a time, with one more write when the entry sinks to a leaf; the
// input reopens once every lane is idle.
// Read: empty slots are skipped and each nonzero entry is fetched and shown
// until the last beat or the end of the heap; an output stall holds the beat.
// Reset leaves every heap empty at once through per-slot valid bits.
// ============================================================================
module multi_metric_top_n_tracker
    import mmtn_pkg::*;
#(
    parameter int HEAP_SLOTS   = DEF_HEAP_SLOTS,
    parameter int METRIC_COUNT = DEF_METRIC_COUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [CMD_W-1:0]   command,
    input  logic [DATA_W-1:0]  ip_address,
    input  logic [DATA_W-1:0]  packets_in_rate,
    input  logic [DATA_W-1:0]  packets_out_rate,
    input  logic [DATA_W-1:0]  bytes_in_rate,
    input  logic [DATA_W-1:0]  bytes_out_rate,
    input  logic [DATA_W-1:0]  new_session_rate,
    input  logic [DATA_W-1:0]  new_web_session_rate,
    input  logic [DATA_W-1:0]  icmp_bytes_rate,
    input  logic [DATA_W-1:0]  web_bytes_rate,
    input  logic [SEL_W-1:0]   metric_select,
    input  logic [LIMIT_W-1:0] read_limit,
    output logic               entry_valid,
    input  logic               entry_stall,
    output logic [DATA_W-1:0]  entry_ip,
    output logic [DATA_W-1:0]  entry_value,
    output logic               last_entry
);

    localparam int SW = slot_bits(HEAP_SLOTS);

    top_state_t state_reg, state_next;
    cmd_t               cmd_reg;
    logic [DATA_W-1:0]  ip_reg;
    logic [DATA_W-1:0]  rate_reg [RATE_COUNT];
    logic [DATA_W-1:0]  rate_in [RATE_COUNT];
    logic [SEL_W-1:0]   sel_reg;
    logic [LIMIT_W-1:0] limit_reg;

    lane_cmd_t             lane_cmd;
    rdr_cmd_t              rdr_cmd;
    logic                  rdr_busy;
    logic                  scan_en;
    logic [SW-1:0]         scan_addr;
    logic [METRIC_COUNT-1:0] lane_busy;
    logic [HEAP_SLOTS-1:0] lane_nz [METRIC_COUNT];
    logic [DATA_W-1:0]     lane_ip [METRIC_COUNT];
    logic [DATA_W-1:0]     lane_value [METRIC_COUNT];

    assign rate_in[0] = packets_in_rate;
    assign rate_in[1] = packets_out_rate;
    assign rate_in[2] = bytes_in_rate;
    assign rate_in[3] = bytes_out_rate;
    assign rate_in[4] = new_session_rate;
    assign rate_in[5] = new_web_session_rate;
    assign rate_in[6] = icmp_bytes_rate;
    assign rate_in[7] = web_bytes_rate;

    assign item_stall = (state_reg != T_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        lane_cmd.clear   = 1'b0;
        lane_cmd.start   = 1'b0;
        rdr_cmd.start    = 1'b0;
        rdr_cmd.sel      = sel_reg;
        rdr_cmd.limit    = limit_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = T_EXEC;
                end
            end
            T_EXEC:
            begin
                case (cmd_reg)
                    CMD_CLEAR:
                    begin
                        lane_cmd.clear = 1'b1;
                        state_next     = T_IDLE;
                    end
                    CMD_OFFER:
                    begin
                        lane_cmd.start = 1'b1;
                        state_next     = T_WAIT_LANES;
                    end
                    CMD_READ:
                    begin
                        rdr_cmd.start = 1'b1;
                        state_next    = T_WAIT_READ;
                    end
                    default:
                    begin
                        state_next = T_IDLE;
                    end
                endcase
            end
            T_WAIT_LANES:
            begin
                if (!(|lane_busy))
                begin
                    state_next = T_IDLE;
                end
            end
            T_WAIT_READ:
            begin
                if (!rdr_busy)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            cmd_reg   <= cmd_t'(command);
            ip_reg    <= ip_address;
            sel_reg   <= metric_select;
            limit_reg <= read_limit;
            for (int i = 0; i < RATE_COUNT; i++)
            begin
                rate_reg[i] <= rate_in[i];
            end
        end
    end

    for (genvar g = 0; g < METRIC_COUNT; g++)
    begin : g_lane
        mmtn_lane #(
            .HEAP_SLOTS (HEAP_SLOTS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (lane_cmd),
            .offer_ip   (ip_reg),
            .offer_rate (rate_reg[g]),
            .scan_en    (scan_en),
            .scan_addr  (scan_addr),
            .busy       (lane_busy[g]),
            .nz_mask    (lane_nz[g]),
            .rd_ip      (lane_ip[g]),
            .rd_value   (lane_value[g])
        );
    end

    mmtn_reader #(
        .HEAP_SLOTS   (HEAP_SLOTS),
        .METRIC_COUNT (METRIC_COUNT)
    ) u_reader (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (rdr_cmd),
        .nz_mask     (lane_nz),
        .lane_ip     (lane_ip),
        .lane_value  (lane_value),
        .scan_en     (scan_en),
        .scan_addr   (scan_addr),
        .busy        (rdr_busy),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry_ip    (entry_ip),
        .entry_value (entry_value),
        .last_entry  (last_entry)
    );

endmodule

// ===== design/mmtn_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and two read ports, read data registered.
// ============================================================================
module mmtn_ram
    import mmtn_pkg::*;
#(
    parameter int WIDTH = 2 * DATA_W,
    parameter int DEPTH = DEF_HEAP_SLOTS
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [slot_bits(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]            wr_data,
    input  logic [slot_bits(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]            rd_a_data,
    input  logic [slot_bits(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]            rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== design/mmtn_lane.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Heap lane
// One min-heap in RAM with per-slot valid bits; replaces the root on a
// larger offer and sifts it down one level per cycle.
// ============================================================================
module mmtn_lane
    import mmtn_pkg::*;
#(
    parameter int HEAP_SLOTS = DEF_HEAP_SLOTS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lane_cmd_t                        cmd,
    input  logic [DATA_W-1:0]                offer_ip,
    input  logic [DATA_W-1:0]                offer_rate,
    input  logic                             scan_en,
    input  logic [slot_bits(HEAP_SLOTS)-1:0] scan_addr,
    output logic                             busy,
    output logic [HEAP_SLOTS-1:0]            nz_mask,
    output logic [DATA_W-1:0]                rd_ip,
    output logic [DATA_W-1:0]                rd_value
);

    localparam int SW = slot_bits(HEAP_SLOTS);
    localparam int CW = SW + 2;
    localparam logic [CW-1:0] SLOTS_C = CW'(HEAP_SLOTS);

    lane_state_t state_reg, state_next;
    logic [SW-1:0]         pos_reg, pos_next;
    logic [HEAP_SLOTS-1:0] valid_reg;
    logic [HEAP_SLOTS-1:0] nz_reg;
    logic [DATA_W-1:0]     root_reg;
    logic                  va_reg, vb_reg, right_ok_reg;

    logic [SW-1:0]         nxt_pos;
    logic [CW-1:0]         nl_full, nr_full, cl_full, cr_full;
    logic                  left_ok_n, right_ok_n;
    logic [SW-1:0]         rd_a_addr, rd_b_addr;
    logic                  wr_en;
    logic [SW-1:0]         wr_addr;
    logic [2*DATA_W-1:0]   wr_data;
    logic [2*DATA_W-1:0]   ram_a, ram_b;
    logic [DATA_W-1:0]     a_val, b_val, a_ip, b_ip;
    logic                  pick_right;
    logic [SW-1:0]         pick_addr;
    logic [DATA_W-1:0]     pick_ip, pick_val;

    assign cl_full    = CW'({pos_reg, 1'b1});
    assign cr_full    = cl_full + CW'(1);
    assign a_val      = va_reg ? ram_a[DATA_W-1:0] : '0;
    assign a_ip       = va_reg ? ram_a[2*DATA_W-1:DATA_W] : '0;
    assign b_val      = vb_reg ? ram_b[DATA_W-1:0] : '0;
    assign b_ip       = vb_reg ? ram_b[2*DATA_W-1:DATA_W] : '0;
    assign pick_right = right_ok_reg && (a_val > b_val);
    assign pick_addr  = pick_right ? cr_full[SW-1:0] : cl_full[SW-1:0];
    assign pick_ip    = pick_right ? b_ip : a_ip;
    assign pick_val   = pick_right ? b_val : a_val;

    assign nxt_pos    = (state_reg == L_SIFT) ? pick_addr : '0;
    assign nl_full    = CW'({nxt_pos, 1'b1});
    assign nr_full    = nl_full + CW'(1);
    assign left_ok_n  = nl_full < SLOTS_C;
    assign right_ok_n = nr_full < SLOTS_C;
    assign rd_a_addr  = scan_en ? scan_addr : (left_ok_n ? nl_full[SW-1:0] : '0);
    assign rd_b_addr  = right_ok_n ? nr_full[SW-1:0] : '0;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = {offer_ip, offer_rate};
        case (state_reg)
            L_IDLE:
            begin
                if (cmd.start && (offer_rate > root_reg))
                begin
                    if (left_ok_n)
                    begin
                        state_next = L_SIFT;
                        pos_next   = '0;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                    end
                end
            end
            L_SIFT:
            begin
                wr_en = 1'b1;
                if (offer_rate > pick_val)
                begin
                    wr_data    = {pick_ip, pick_val};
                    pos_next   = pick_addr;
                    state_next = left_ok_n ? L_SIFT : L_LAST;
                end
                else
                begin
                    state_next = L_IDLE;
                end
            end
            L_LAST:
            begin
                wr_en      = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= L_IDLE;
            pos_reg      <= '0;
            valid_reg    <= '0;
            nz_reg       <= '0;
            root_reg     <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            right_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            va_reg       <= valid_reg[rd_a_addr];
            vb_reg       <= valid_reg[rd_b_addr];
            right_ok_reg <= right_ok_n;
            if (cmd.clear)
            begin
                valid_reg <= '0;
                nz_reg    <= '0;
                root_reg  <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
                nz_reg[wr_addr]    <= |wr_data[2*DATA_W-1:DATA_W];
                if (wr_addr == '0)
                begin
                    root_reg <= wr_data[DATA_W-1:0];
                end
            end
        end
    end

    mmtn_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (HEAP_SLOTS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (ram_a),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (ram_b)
    );

    assign busy     = (state_reg != L_IDLE);
    assign nz_mask  = nz_reg;
    assign rd_ip    = ram_a[2*DATA_W-1:DATA_W];
    assign rd_value = ram_a[DATA_W-1:0];

endmodule

// ===== design/mmtn_reader.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Read merger
// Selects one lane, walks its nonzero slots in order and presents each
// entry through an output register, flagging the last one.
// ============================================================================
module mmtn_reader
    import mmtn_pkg::*;
#(
    parameter int HEAP_SLOTS   = DEF_HEAP_SLOTS,
    parameter int METRIC_COUNT = DEF_METRIC_COUNT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rdr_cmd_t                         cmd,
    input  logic [HEAP_SLOTS-1:0]            nz_mask [METRIC_COUNT],
    input  logic [DATA_W-1:0]                lane_ip [METRIC_COUNT],
    input  logic [DATA_W-1:0]                lane_value [METRIC_COUNT],
    output logic                             scan_en,
    output logic [slot_bits(HEAP_SLOTS)-1:0] scan_addr,
    output logic                             busy,
    output logic                             entry_valid,
    input  logic                             entry_stall,
    output logic [DATA_W-1:0]                entry_ip,
    output logic [DATA_W-1:0]                entry_value,
    output logic                             last_entry
);

    localparam int SW = slot_bits(HEAP_SLOTS);
    localparam int PW = SW + 1;
    localparam int MW = slot_bits(METRIC_COUNT);
    localparam logic [PW-1:0]      SLOTS_C = PW'(HEAP_SLOTS);
    localparam logic [SEL_W:0]     LANES_C = (SEL_W + 1)'(METRIC_COUNT);
    localparam logic [LIMIT_W-1:0] MAXR_C  = LIMIT_W'(MAX_RESULTS);

    rdr_state_t state_reg, state_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic [LIMIT_W-1:0] cnt_reg, cnt_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [MW-1:0]      lane_reg, lane_next;
    logic [DATA_W-1:0]  ip_reg, value_reg;
    logic               last_reg;

    logic [HEAP_SLOTS-1:0] sel_mask;
    logic [LIMIT_W-1:0]    limit_eff;
    logic                  sel_ok, at_end, more;
    logic                  load;

    assign sel_mask  = nz_mask[lane_reg];
    assign limit_eff = (cmd.limit > MAXR_C) ? MAXR_C : cmd.limit;
    assign sel_ok    = {1'b0, cmd.sel} < LANES_C;
    assign at_end    = ptr_reg >= SLOTS_C;
    assign scan_addr = ptr_reg[SW-1:0];

    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < HEAP_SLOTS; i++)
        begin
            if (sel_mask[i] && (PW'(i) > ptr_reg))
            begin
                more = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        limit_next = limit_reg;
        lane_next  = lane_reg;
        scan_en    = 1'b0;
        load       = 1'b0;
        case (state_reg)
            R_IDLE:
            begin
                if (cmd.start && sel_ok && (limit_eff != '0))
                begin
                    state_next = R_SCAN;
                    ptr_next   = '0;
                    cnt_next   = '0;
                    limit_next = limit_eff;
                    lane_next  = cmd.sel[MW-1:0];
                end
            end
            R_SCAN:
            begin
                if (at_end)
                begin
                    state_next = R_IDLE;
                end
                else if (sel_mask[ptr_reg[SW-1:0]])
                begin
                    scan_en    = 1'b1;
                    state_next = R_FETCH;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end
            R_FETCH:
            begin
                load       = 1'b1;
                state_next = R_SHOW;
            end
            R_SHOW:
            begin
                if (!entry_stall)
                begin
                    cnt_next   = cnt_reg + LIMIT_W'(1);
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = last_reg ? R_IDLE : R_SCAN;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            limit_reg <= '0;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            lane_reg  <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ip_reg    <= lane_ip[lane_reg];
            value_reg <= lane_value[lane_reg];
            last_reg  <= ((cnt_reg + LIMIT_W'(1)) == limit_reg) || !more;
        end
    end

    assign busy        = (state_reg != R_IDLE);
    assign entry_valid = (state_reg == R_SHOW);
    assign entry_ip    = ip_reg;
    assign entry_value = value_reg;
    assign last_entry  = last_reg;

endmodule

// ===== design/mmtn_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Port checker
// Watches the top level's channels for ordering and payload rules.
// ============================================================================
module mmtn_checker
    import mmtn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              entry_valid,
    input logic              entry_stall,
    input logic [DATA_W-1:0] entry_ip,
    input logic [DATA_W-1:0] entry_value,
    input logic              last_entry
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_stall |=> entry_valid && $stable(entry_ip)
            && $stable(entry_value) && $stable(last_entry))
        else $error("stalled result beat changed");

    // The input side stays closed while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid |-> item_stall)
        else $error("input open while a result is pending");

    // An accepted item closes the input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not closed after accept");

    // No result beat follows directly on an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> !entry_valid)
        else $error("result beat right after accept");

    // Slots with a zero address never appear on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid |-> entry_ip != '0)
        else $error("result beat with a zero address");

endmodule

bind multi_metric_top_n_tracker mmtn_checker u_checker (.*);
